/* design/wbps_pkg.sv */
// -----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// -----------------------------------------------------------------------------
package wbps_pkg;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO = 2'd0,
    CFG_PAT_HI = 2'd1,
    CFG_WMASK  = 2'd2,
    CFG_PLEN   = 2'd3
  } cfg_reg_e;

  // Pattern storage is fixed by the register map: sixteen bytes
  localparam int PAT_BYTES = 16;
  localparam int PAT_IDX_W = 4;
  localparam int LEN_W     = 5;
  localparam int MASK_W    = 16;

  // Reported offset field
  localparam int RES_OFS_W = 32;

  typedef struct packed {
    logic                 found;
    logic [RES_OFS_W-1:0] match_offset;
  } res_t;

endpackage : wbps_pkg

/* design/wbps_in_if.sv */
// -----------------------------------------------------------------------------
// wbps_in_if
// Byte stream channel: one byte per transaction with region markers.
// -----------------------------------------------------------------------------
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_region;
  logic       last_of_region;

  modport source (output valid, output data_byte, output first_of_region,
                  output last_of_region, input ready);
  modport sink   (input valid, input data_byte, input first_of_region,
                  input last_of_region, output ready);
endinterface : wbps_in_if

/* design/wbps_out_if.sv */
// -----------------------------------------------------------------------------
// wbps_out_if
// Result channel: found flag and match start offset.
// -----------------------------------------------------------------------------
interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface : wbps_out_if

/* design/wbps_cell.sv */
// -----------------------------------------------------------------------------
// wbps_cell
// One window position: holds a byte, hands it on, compares its next value.
// -----------------------------------------------------------------------------
module wbps_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,  // transaction accepted this cycle
  input  logic       clr_i,    // load zero instead of the neighbour's byte
  input  logic [7:0] byte_i,   // byte from the newer neighbour
  input  logic [7:0] pat_i,    // aligned pattern byte for this position
  input  logic       care_i,   // position in use and not a wildcard
  output logic [7:0] byte_o,   // held byte, to the older neighbour
  output logic       hit_o     // next value satisfies this position
);

  logic [7:0] byte_d, byte_q;

  assign byte_d = clr_i ? 8'h00 : byte_i;
  assign hit_o  = !care_i || (byte_d == pat_i);
  assign byte_o = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (shift_i) begin
      byte_q <= byte_d;
    end
  end

endmodule : wbps_cell

/* design/wbps_res_fifo.sv */
// -----------------------------------------------------------------------------
// wbps_res_fifo
// Two-entry result buffer between the scan chain and the result channel.
// -----------------------------------------------------------------------------
module wbps_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wbps_pkg::res_t  data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output wbps_pkg::res_t  data_o
);
  import wbps_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_d, cnt_q;
  logic       do_pop;

  assign do_pop  = pop_i && valid_o;
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule : wbps_res_fifo

/* design/wildcard_byte_pattern_scan.sv */
// -----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Finds the first window of a byte region that matches a wildcard pattern.
// -----------------------------------------------------------------------------
// Usage:
//   Software fills the pattern bytes, wildcard mask and pattern length through
//   the write port (cfg_we_i / cfg_idx_i / cfg_data_i) while the block is idle.
//   The region is then streamed in on in_i, one byte per transaction, with
//   first_of_region on its first byte and last_of_region on its final byte.
//   For each region exactly one transaction leaves on out_o: found = 1 with
//   the start offset of the first matching window, or found = 0 and offset 0
//   once the last byte passes with no match. Bytes after a report are taken
//   and counted but not tested until the next first_of_region.
//   Throughput: one byte per cycle. The window is a row of MAX_PATTERN cells
//   that shift every accepted byte and compare in parallel, so a byte and its
//   match decision complete in the cycle they are accepted.
//   Each result is registered in the result buffer and shown on out_o once
//   it reaches the head of that buffer.
//   A two-entry result buffer lets in_i keep accepting while a result waits;
//   in_i.ready drops only when both entries are held by a stalled receiver.
//   Reset clears the window, byte count, done mark and result buffer, and
//   restores the registers (pattern length returns to one).
// -----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wbps_in_if.sink                       in_i,
  wbps_out_if.source                    out_o
);
  import wbps_pkg::*;

  localparam logic [LEN_W-1:0]       MaxLen   = LEN_W'(MAX_PATTERN);
  localparam logic [OFFSET_BITS-1:0] CountMax = '1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
  logic [MASK_W-1:0]     wmask_q;
  logic [LEN_W-1:0]      plen_q;
  cfg_reg_e              cfg_sel;

  assign cfg_sel = cfg_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      wmask_q  <= '0;
      plen_q   <= LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        CFG_PAT_LO: pat_lo_q <= cfg_data_i;
        CFG_PAT_HI: pat_hi_q <= cfg_data_i;
        CFG_WMASK:  wmask_q  <= cfg_data_i[MASK_W-1:0];
        CFG_PLEN:   plen_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to 1 .. MAX_PATTERN
  logic [LEN_W-1:0] len;
  always_comb begin
    len = plen_q;
    if (plen_q == '0) begin
      len = LEN_W'(1);
    end else if (plen_q > MaxLen) begin
      len = MaxLen;
    end
  end

  // Pattern as a byte array, byte 0 first
  logic [7:0] pat_byte [PAT_BYTES];
  for (genvar b = 0; b < PAT_BYTES / 2; b++) begin : g_pat
    assign pat_byte[b]                 = pat_lo_q[8*b +: 8];
    assign pat_byte[b + PAT_BYTES / 2] = pat_hi_q[8*b +: 8];
  end

  // ---------------------------------------------------------------------------
  // Stream control
  // ---------------------------------------------------------------------------
  logic                   in_fire, buf_full, push;
  logic                   done_q, done_eff;
  logic [OFFSET_BITS-1:0] seen_d, seen_q, idx, diff;
  logic                   saturated, eligible, all_hit;
  res_t                   res_new, res_head;

  assign in_i.ready = !buf_full;
  assign in_fire    = in_i.valid && in_i.ready;

  // A first byte clears the count and done mark before it is counted
  assign idx       = in_i.first_of_region ? '0 : seen_q;
  assign done_eff  = in_i.first_of_region ? 1'b0 : done_q;
  assign saturated = (idx == CountMax);
  assign seen_d    = saturated ? idx : idx + OFFSET_BITS'(1);
  assign eligible  = !saturated && (idx >= OFFSET_BITS'(len - LEN_W'(1)));
  assign diff      = idx - OFFSET_BITS'(len - LEN_W'(1));

  // ---------------------------------------------------------------------------
  // Window: a row of cells, cell 0 holds the newest byte
  // ---------------------------------------------------------------------------
  logic [7:0]             cell_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_hit;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic                 in_use, care;
    logic [PAT_IDX_W-1:0] pidx;
    logic [7:0]           nbr;

    // Cell k is compared with pattern byte len-1-k
    assign in_use = (LEN_W'(k) < len);
    assign pidx   = PAT_IDX_W'(len - LEN_W'(k) - LEN_W'(1));
    assign care   = in_use && !wmask_q[pidx];

    if (k == 0) begin : g_head
      assign nbr = in_i.data_byte;
    end else begin : g_body
      assign nbr = cell_byte[k-1];
    end

    wbps_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(in_fire),
      .clr_i  ((k != 0) && in_i.first_of_region),
      .byte_i (nbr),
      .pat_i  (pat_byte[pidx]),
      .care_i (care),
      .byte_o (cell_byte[k]),
      .hit_o  (cell_hit[k])
    );
  end

  assign all_hit = &cell_hit;

  // ---------------------------------------------------------------------------
  // Report decision
  // ---------------------------------------------------------------------------
  always_comb begin
    push    = 1'b0;
    res_new = '0;
    if (in_fire && !done_eff) begin
      if (eligible && all_hit) begin
        push                 = 1'b1;
        res_new.found        = 1'b1;
        res_new.match_offset = RES_OFS_W'(diff);
      end else if (in_i.last_of_region) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      done_q <= 1'b0;
    end else if (in_fire) begin
      seen_q <= seen_d;
      done_q <= done_eff || push;
    end
  end

  // ---------------------------------------------------------------------------
  // Result buffer and channel
  // ---------------------------------------------------------------------------
  wbps_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res_new),
    .full_o (buf_full),
    .valid_o(out_o.valid),
    .pop_i  (out_o.ready),
    .data_o (res_head)
  );

  assign out_o.found        = res_head.found;
  assign out_o.match_offset = res_head.match_offset;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> (out_o.match_offset == '0))
    else $error("not-found result carries a non-zero offset");

  a_push_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> done_q)
    else $error("done mark not set after a report");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !(in_fire && in_i.first_of_region)) |=> done_q)
    else $error("done mark dropped without a new region");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no result waiting");

endmodule : wildcard_byte_pattern_scan

/* tb/sv/wildcard_byte_pattern_scan_test.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_test
// Self-checking bench for the wildcard byte pattern scanner: a short table of
// directed bytes and register writes, then regions of random bytes with
// planted patterns under several register settings. Every result transaction
// is checked against an in-bench model of the scan, with random idling on
// both channels, one long receiver hold-off and a stall watchdog.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wbps_pkg::*;

  localparam int ITEM_TARGET  = 1900;  // bytes sent in the random part
  localparam int PHASE_ITEMS  = 150;   // bytes sent per register setting
  localparam int IDLE_PCT     = 34;    // idle cycles per hundred, each side
  localparam int HOLD_CYCLES  = 120;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 4;     // wait after the last expected report
  localparam int STALL_LIMIT  = 1000;  // cycles with no transaction at all

  typedef enum logic [1:0] {ROW_CFG, ROW_BYTE} row_kind_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TYPED} exp_mode_e;

  typedef struct packed {
    row_kind_e  kind;
    cfg_reg_e   reg_sel;
    logic [63:0] value;
    logic [7:0] data;
    logic       first;
    logic       last;
    exp_mode_e  mode;
    res_t       result;
  } dir_row_t;

  // Clock, reset and the block's ports
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  wbps_in_if  in_ch ();
  wbps_out_if out_ch ();

  wildcard_byte_pattern_scan dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Scan model state: register copies, byte window (newest at 0), byte count
  // and the mark that the region has already reported.
  logic [63:0] pat_lo_q;
  logic [63:0] pat_hi_q;
  logic [15:0] wmask_q;
  logic [4:0]  plen_q;
  logic [7:0]  win_q [16];
  logic [31:0] seen_q;
  bit          done_q;

  res_t        pending_reports [$];
  int unsigned scanned_items = 0;
  int unsigned error_count   = 0;
  int          stall_cycles  = 0;

  // Idling controls for the byte sender and the receiver process
  int src_idle_pct  = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  bit hold_req      = 1'b0;
  int hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Length zero counts as one, anything over sixteen as sixteen
  function automatic int eff_len();
    int n;
    n = int'(plen_q);
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    return n;
  endfunction

  // Advance the scan by one accepted byte; returns 1 with the report it causes
  function automatic bit scan_next_byte(input logic [7:0] b, input logic f,
                                        input logic l, output res_t r);
    int          len;
    int          j;
    logic [31:0] idx;
    logic [32:0] idx_inc;
    bit          sat;
    bit          hit;
    logic [127:0] pat;
    r   = '0;
    len = eff_len();
    pat = {pat_hi_q, pat_lo_q};
    if (f) begin
      for (j = 0; j < 16; j++) win_q[j] = '0;
      seen_q = '0;
      done_q = 1'b0;
    end
    for (j = 15; j > 0; j--) win_q[j] = win_q[j-1];
    win_q[0] = b;
    // A byte arriving at the saturated count is shifted in but never tested
    idx = seen_q;
    sat = (idx == '1);
    if (!sat) seen_q = idx + 32'd1;
    if (done_q) return 1'b0;
    idx_inc = {1'b0, idx} + 33'd1;
    if (!sat && idx_inc >= 33'(len)) begin
      // Pattern byte 0 lines up with the oldest byte of the window
      hit = 1'b1;
      for (j = 0; j < len; j++)
        if (!wmask_q[j] && win_q[len-1-j] != pat[8*j +: 8]) hit = 1'b0;
      if (hit) begin
        done_q         = 1'b1;
        r.found        = 1'b1;
        r.match_offset = 32'(idx_inc - 33'(len));
        return 1'b1;
      end
    end
    // Region over with no match: report not found once
    if (l) begin
      done_q = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] d, input logic f,
                                        input logic l, input exp_mode_e m,
                                        input logic fnd, input logic [31:0] ofs);
    dir_row_t row;
    row                    = '0;
    row.kind               = ROW_BYTE;
    row.data               = d;
    row.first              = f;
    row.last               = l;
    row.mode               = m;
    row.result.found       = fnd;
    row.result.match_offset = ofs;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input cfg_reg_e sel, input logic [63:0] v);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_sel = sel;
    row.value   = v;
    return row;
  endfunction

  // Write one register; the model takes the value at the same time, since
  // writes only happen while the block is idle.
  task automatic write_reg(input cfg_reg_e sel, input logic [63:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= v;
    case (sel)
      CFG_PAT_LO: pat_lo_q = v;
      CFG_PAT_HI: pat_hi_q = v;
      CFG_WMASK:  wmask_q  = v[15:0];
      CFG_PLEN:   plen_q   = v[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one byte, idling at random first, and hold it until taken.
  // Valid stays high after acceptance so the next byte can follow directly.
  task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
                           input exp_mode_e mode, input res_t typed);
    res_t r;
    bit   got;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.data_byte       <= b;
    in_ch.first_of_region <= f;
    in_ch.last_of_region  <= l;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    scanned_items++;
    got = scan_next_byte(b, f, l, r);
    case (mode)
      EXP_MODEL: if (got) pending_reports.insert(pending_reports.size(), r);
      EXP_TYPED: pending_reports.insert(pending_reports.size(), typed);
      default: ;
    endcase
  endtask

  // Drop valid and hold off until every expected report has arrived
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One region: random bytes, a third of them drawn from pattern bytes,
  // often with the whole pattern planted. Now and then drop the first or
  // last marker, or trail a few stray bytes behind the region.
  task automatic run_region(input int max_len);
    logic [7:0]   region_bytes [64];
    logic [127:0] pat;
    int           n;
    int           plen_e;
    int           pos;
    int           k;
    int           trail;
    bit           use_first;
    bit           use_last;
    pat    = {pat_hi_q, pat_lo_q};
    plen_e = eff_len();
    n = ($urandom_range(19) == 0) ? $urandom_range(1, 64) : $urandom_range(1, max_len);
    for (k = 0; k < n; k++)
      region_bytes[k] = ($urandom_range(2) == 0) ?
                        pat[8*$urandom_range(plen_e-1) +: 8] : 8'($urandom_range(255));
    if ($urandom_range(1) == 0 && n >= plen_e) begin
      pos = $urandom_range(n - plen_e);
      for (k = 0; k < plen_e; k++)
        if (!wmask_q[k]) region_bytes[pos+k] = pat[8*k +: 8];
    end
    use_first = ($urandom_range(9) != 0);
    use_last  = ($urandom_range(9) != 0);
    for (k = 0; k < n; k++)
      send_byte(region_bytes[k], use_first && k == 0, use_last && k == n - 1,
                EXP_MODEL, '0);
    if ($urandom_range(7) == 0) begin
      trail = $urandom_range(1, 3);
      for (k = 0; k < trail; k++)
        send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), EXP_MODEL, '0);
    end
  endtask

  // Receiver: random ready, or a long hold-off when asked for one
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Check each result transaction against the oldest expected report
  always @(posedge clk) begin : check_results
    res_t exp_r;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: found %0b match_offset %0d",
               out_ch.found, out_ch.match_offset);
        error_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (exp_r.found !== out_ch.found) begin
          $error("found: expected %0b, got %0b", exp_r.found, out_ch.found);
          error_count++;
        end
        if (exp_r.match_offset !== out_ch.match_offset) begin
          $error("match_offset: expected %0d, got %0d",
                 exp_r.match_offset, out_ch.match_offset);
          error_count++;
        end
      end
    end
  end

  // End the run when neither channel has moved for too long
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    directed [$];
    int          k;
    int          phase;
    int unsigned phase_start;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] mask;
    int          len;

    in_ch.valid           <= 1'b0;
    in_ch.data_byte       <= '0;
    in_ch.first_of_region <= 1'b0;
    in_ch.last_of_region  <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_data              <= '0;
    rst_n                 <= 1'b0;

    // Model registers and state after reset
    pat_lo_q = '0;
    pat_hi_q = '0;
    wmask_q  = '0;
    plen_q   = 5'd1;
    for (k = 0; k < 16; k++) win_q[k] = '0;
    seen_q   = '0;
    done_q   = 1'b0;

    // Reset defaults: pattern one zero byte, no wildcards
    directed.insert(directed.size(), byte_row(8'h00, 1'b1, 1'b0, EXP_TYPED, 1'b1, 32'd0));
    // Region already reported: the last byte passes silently
    directed.insert(directed.size(), byte_row(8'h55, 1'b0, 1'b1, EXP_NONE, 1'b0, 32'd0));
    // Single-byte region with no match
    directed.insert(directed.size(), byte_row(8'hFF, 1'b1, 1'b1, EXP_TYPED, 1'b0, 32'd0));
    // Match on the last byte: found, and no not-found after it
    directed.insert(directed.size(), byte_row(8'hFF, 1'b1, 1'b0, EXP_NONE, 1'b0, 32'd0));
    directed.insert(directed.size(), byte_row(8'h00, 1'b0, 1'b1, EXP_TYPED, 1'b1, 32'd1));
    // All-ones pattern, length over the limit so sixteen bytes are used
    directed.insert(directed.size(), cfg_row(CFG_PAT_LO, '1));
    directed.insert(directed.size(), cfg_row(CFG_PAT_HI, '1));
    directed.insert(directed.size(), cfg_row(CFG_PLEN, 64'd31));
    for (k = 0; k < 16; k++)
      directed.insert(directed.size(),
                      byte_row(8'hFF, k == 0, k == 15,
                               (k == 15) ? EXP_TYPED : EXP_NONE, k == 15, 32'd0));
    // Length zero acts as one; all wildcards match anything
    directed.insert(directed.size(), cfg_row(CFG_WMASK, 64'hFFFF));
    directed.insert(directed.size(), cfg_row(CFG_PLEN, 64'd0));
    directed.insert(directed.size(), byte_row(8'h80, 1'b1, 1'b1, EXP_TYPED, 1'b1, 32'd0));
    // Three bytes with a wildcard in the middle, matching at offset one
    directed.insert(directed.size(), cfg_row(CFG_PAT_LO, 64'h0000_0000_0034_AB12));
    directed.insert(directed.size(), cfg_row(CFG_WMASK, 64'h0002));
    directed.insert(directed.size(), cfg_row(CFG_PLEN, 64'd3));
    directed.insert(directed.size(), byte_row(8'h12, 1'b1, 1'b0, EXP_MODEL, 1'b0, 32'd0));
    directed.insert(directed.size(), byte_row(8'h12, 1'b0, 1'b0, EXP_MODEL, 1'b0, 32'd0));
    directed.insert(directed.size(), byte_row(8'h99, 1'b0, 1'b0, EXP_MODEL, 1'b0, 32'd0));
    directed.insert(directed.size(), byte_row(8'h34, 1'b0, 1'b1, EXP_MODEL, 1'b0, 32'd0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < directed.size(); k++) begin
      if (directed[k].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed[k].reg_sel, directed[k].value);
      end else begin
        send_byte(directed[k].data, directed[k].first, directed[k].last,
                  directed[k].mode, directed[k].result);
      end
    end

    // Random part: a new register setting per phase, each phase starting
    // from an idle block once every report has come back
    scanned_items = 0;
    phase         = 0;
    while (scanned_items < ITEM_TARGET) begin
      drain_results();
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      mask = 16'($urandom & $urandom);
      len  = ($urandom_range(3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
      case (phase)
        0: begin len = 1;  mask = '0; end
        1: begin len = 16; mask = '0; end
        2: len = 2;
        3: begin len = 0;  mask = '1; end
        4: len = 31;
        5: begin len = 17; lo = '0; hi = '0; mask = '0; end
        6: begin len = 16; lo = '1; hi = '1; mask = '1; end
        default: ;
      endcase
      write_reg(CFG_PAT_LO, lo);
      write_reg(CFG_PAT_HI, hi);
      // Junk above the register width must be ignored
      write_reg(CFG_WMASK, {$urandom, 16'($urandom), mask});
      write_reg(CFG_PLEN, {$urandom, 27'($urandom), 5'(len)});
      // First phase runs with no idling on either side
      src_idle_pct  = (phase == 0) ? 0 : IDLE_PCT;
      sink_idle_pct = (phase == 0) ? 0 : IDLE_PCT;
      // Hold the receiver off while short regions pile up reports
      if (phase == 2) hold_req = 1'b1;
      phase_start = scanned_items;
      while (scanned_items - phase_start < PHASE_ITEMS)
        run_region((phase == 2) ? 3 : 24);
      phase++;
    end

    drain_results();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule : wildcard_byte_pattern_scan_test
